// ===== hdl/acss_pkg.sv =====
`timescale 1ns / 1ps

package acss_pkg;

    // Scan list geometry
    localparam int MAX_SLOTS_DEFAULT = 4;
    localparam int CFG_SLOTS         = 4;   // slots that carry an id and ratio field
    localparam int CHAN_W            = 5;
    localparam int RATIO_W           = 16;

    // Register map
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam logic [CFG_INDEX_W-1:0] REG_REFERENCE_MV   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_IDS    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DIVIDER_RATIOS = 2'd3;

    localparam logic [15:0] REFERENCE_MV_RESET = 16'd3300;

    // Scaling: mv = round(p / (4095 * 4096)), p = sample * ref * ratio
    localparam logic [RATIO_W-1:0] Q_ONE       = 16'd4096;
    localparam logic [44:0]        ROUND_HALF  = 45'd8386560;       // (4095*4096)/2
    localparam logic [32:0]        SAT_LIMIT   = 33'd268369920;     // 65536*4095
    localparam logic [28:0]        RECIP_M     = 29'd268501008;     // floor(2^40/4095)
    localparam logic [27:0]        ADC_FULL    = 28'd4095;
    localparam logic [15:0]        MV_MAX      = 16'hFFFF;

    // Stream widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    typedef enum logic [1:0] {
        KIND_START      = 2'd0,
        KIND_CONV_DONE  = 2'd1,
        KIND_READ_FINAL = 2'd2,
        KIND_READ_RAW   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_CHAN   = 2'd1,
        STAT_NO_DATA   = 2'd2,
        STAT_REJECTED  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_ROUND,
        S_RECIP,
        S_COMMIT,
        S_LOOKUP
    } fsm_state_t;

    typedef struct packed {
        logic load_in;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_is_conv;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/acss_ctrl.sv =====
`timescale 1ns / 1ps

module acss_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  acss_pkg::dp_status_t  dp_status,
    output acss_pkg::ctrl_cmd_t   cmd
);

    acss_pkg::fsm_state_t state_reg, state_next;
    logic accepted;

    assign accepted = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= acss_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            acss_pkg::S_IDLE: begin
                if (accepted) begin
                    state_next = dp_status.in_is_conv ? acss_pkg::S_MUL_A : acss_pkg::S_LOOKUP;
                end
            end
            acss_pkg::S_LOOKUP: state_next = acss_pkg::S_COMMIT;
            acss_pkg::S_MUL_A:  state_next = acss_pkg::S_MUL_B;
            acss_pkg::S_MUL_B:  state_next = acss_pkg::S_ROUND;
            acss_pkg::S_ROUND:  state_next = acss_pkg::S_RECIP;
            acss_pkg::S_RECIP:  state_next = acss_pkg::S_COMMIT;
            acss_pkg::S_COMMIT: begin
                if (dp_status.out_free) begin
                    state_next = acss_pkg::S_IDLE;
                end
            end
            default: state_next = acss_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.load_in = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            acss_pkg::S_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            acss_pkg::S_COMMIT: begin
                cmd.commit = dp_status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hdl/acss_datapath.sv =====
`timescale 1ns / 1ps

module acss_datapath #(
    parameter int MAX_SLOTS = acss_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [acss_pkg::S_TDATA_W-1:0]        s_tdata,
    input  logic [1:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [acss_pkg::M_TDATA_W-1:0]        m_tdata,
    input  logic                                  cfg_we,
    input  logic [acss_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [acss_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  acss_pkg::ctrl_cmd_t                   cmd,
    output acss_pkg::dp_status_t                  dp_status
);

    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CHW   = acss_pkg::CHAN_W;

    // Configuration
    logic [15:0] ref_mv_reg;
    logic [2:0]  chan_count_reg;
    logic [19:0] chan_ids_reg;
    logic [63:0] ratios_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_mv_reg     <= acss_pkg::REFERENCE_MV_RESET;
            chan_count_reg <= 3'd0;
            chan_ids_reg   <= 20'd0;
            ratios_reg     <= 64'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                acss_pkg::REG_REFERENCE_MV:   ref_mv_reg     <= cfg_wdata[15:0];
                acss_pkg::REG_CHANNEL_COUNT:  chan_count_reg <= cfg_wdata[2:0];
                acss_pkg::REG_CHANNEL_IDS:    chan_ids_reg   <= cfg_wdata[19:0];
                acss_pkg::REG_DIVIDER_RATIOS: ratios_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Per-slot hardware id and ratio; slots past the packed fields get id 0, ratio 1.0
    logic [CHW-1:0]                 slot_id    [MAX_SLOTS];
    logic [acss_pkg::RATIO_W-1:0]   slot_ratio [MAX_SLOTS];

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_slot
        if (g < acss_pkg::CFG_SLOTS) begin : g_cfg
            logic [acss_pkg::RATIO_W-1:0] field;
            assign field         = ratios_reg[acss_pkg::RATIO_W*g +: acss_pkg::RATIO_W];
            assign slot_id[g]    = chan_ids_reg[CHW*g +: CHW];
            assign slot_ratio[g] = (field == '0) ? acss_pkg::Q_ONE : field;
        end else begin : g_fixed
            assign slot_id[g]    = '0;
            assign slot_ratio[g] = acss_pkg::Q_ONE;
        end
    end

    logic [CNT_W-1:0] count;
    assign count = (int'(chan_count_reg) < MAX_SLOTS) ? CNT_W'(chan_count_reg)
                                                     : CNT_W'(MAX_SLOTS);

    // Latched input transaction
    acss_pkg::kind_t kind_reg;
    logic [11:0]     sample_reg;
    logic [CHW-1:0]  channel_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            kind_reg    <= acss_pkg::kind_t'(s_tuser);
            sample_reg  <= s_tdata[11:0];
            channel_reg <= s_tdata[16:12];
        end
    end

    // Scan state
    logic [MAX_SLOTS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]     scan_index_reg, scan_index_next;
    logic                 running_reg, running_next;

    // Scaling pipeline, free running; controller waits for it to settle
    logic [acss_pkg::RATIO_W-1:0] ratio_sel;
    logic [27:0] prod_a_reg;
    logic [43:0] prod_p_reg;
    logic [32:0] t_full;
    logic [27:0] t_reg, t_d_reg;
    logic        sat_reg, sat_d_reg;
    logic [56:0] recip_prod;
    logic [15:0] qe_reg;
    logic [27:0] rem;
    logic [15:0] mv;

    assign ratio_sel = (int'(scan_index_reg) < MAX_SLOTS)
                     ? slot_ratio[scan_index_reg[IDX_W-1:0]] : acss_pkg::Q_ONE;
    assign t_full     = 33'(({1'b0, prod_p_reg} + acss_pkg::ROUND_HALF) >> 12);
    assign recip_prod = t_reg * acss_pkg::RECIP_M;

    always_ff @(posedge aclk) begin
        prod_a_reg <= sample_reg * ref_mv_reg;
        prod_p_reg <= prod_a_reg * ratio_sel;
        t_reg      <= t_full[27:0];
        sat_reg    <= (t_full >= acss_pkg::SAT_LIMIT);
        qe_reg     <= recip_prod[55:40];
        t_d_reg    <= t_reg;
        sat_d_reg  <= sat_reg;
    end

    // Estimate is low by at most one
    assign rem = t_d_reg - ({qe_reg, 12'd0} - {12'd0, qe_reg});
    assign mv  = sat_d_reg ? acss_pkg::MV_MAX
                           : (qe_reg + ((rem >= acss_pkg::ADC_FULL) ? 16'd1 : 16'd0));

    // Channel lookup, lowest slot wins
    logic             hit_found;
    logic [IDX_W-1:0] hit_idx;

    always_comb begin
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if ((i < int'(count)) && (slot_id[i] == channel_reg)) begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(i);
            end
        end
    end

    logic [11:0] raw_mem [MAX_SLOTS];
    logic [15:0] mv_mem  [MAX_SLOTS];

    // Registered store read; the lookup state lets it load from the latched channel before commit
    logic [11:0] raw_rd_reg;
    logic [15:0] mv_rd_reg;

    always_ff @(posedge aclk) begin
        raw_rd_reg <= raw_mem[hit_idx];
        mv_rd_reg  <= mv_mem[hit_idx];
    end

    // Commit decision
    acss_pkg::status_t status;
    logic [15:0]       value;
    logic              start_req;
    logic [CHW-1:0]    start_chan;
    logic              store_we;
    logic [CNT_W-1:0]  idx_inc;

    assign idx_inc = scan_index_reg + CNT_W'(1);

    always_comb begin
        valid_next      = valid_reg;
        scan_index_next = scan_index_reg;
        running_next    = running_reg;
        status          = acss_pkg::STAT_REJECTED;
        value           = 16'd0;
        start_req       = 1'b0;
        start_chan      = '0;
        store_we        = 1'b0;
        unique case (kind_reg)
            acss_pkg::KIND_START: begin
                if (!running_reg && (count != '0)) begin
                    for (int i = 0; i < MAX_SLOTS; i++) begin
                        if (i < int'(count)) begin
                            valid_next[i] = 1'b0;
                        end
                    end
                    scan_index_next = '0;
                    running_next    = 1'b1;
                    status          = acss_pkg::STAT_OK;
                    start_req       = 1'b1;
                    start_chan      = slot_id[0];
                end
            end
            acss_pkg::KIND_CONV_DONE: begin
                if (running_reg) begin
                    if (scan_index_reg >= count) begin
                        // count lowered mid-scan
                        running_next = 1'b0;
                    end else begin
                        store_we        = 1'b1;
                        valid_next[scan_index_reg[IDX_W-1:0]] = 1'b1;
                        scan_index_next = idx_inc;
                        status          = acss_pkg::STAT_OK;
                        if (idx_inc >= count) begin
                            running_next = 1'b0;
                        end else begin
                            start_req  = 1'b1;
                            start_chan = slot_id[idx_inc[IDX_W-1:0]];
                        end
                    end
                end
            end
            default: begin
                if (!hit_found) begin
                    status = acss_pkg::STAT_NO_CHAN;
                end else if (!valid_reg[hit_idx]) begin
                    status = acss_pkg::STAT_NO_DATA;
                end else begin
                    status = acss_pkg::STAT_OK;
                    if (kind_reg == acss_pkg::KIND_READ_FINAL) begin
                        value               = mv_rd_reg;
                        valid_next[hit_idx] = 1'b0;
                    end else begin
                        value = {4'd0, raw_rd_reg};
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && store_we) begin
            raw_mem[scan_index_reg[IDX_W-1:0]] <= sample_reg;
            mv_mem[scan_index_reg[IDX_W-1:0]]  <= mv;
        end
    end

    // Output register
    logic                          m_tvalid_reg;
    logic [acss_pkg::M_TDATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            scan_index_reg <= '0;
            running_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cmd.commit) begin
                valid_reg      <= valid_next;
                scan_index_reg <= scan_index_next;
                running_reg    <= running_next;
                m_tvalid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= {7'd0, running_next, start_chan, start_req, value, status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign dp_status.in_is_conv = (s_tuser == acss_pkg::KIND_CONV_DONE);
    assign dp_status.out_free   = !m_tvalid_reg || m_tready;

endmodule

// ===== hdl/adc_channel_scan_scaler.sv =====
`timescale 1ns / 1ps
// Start and read transactions pass the lookup state (registered store read) and then commit;
// conversion-done passes two multiplies, rounding and a reciprocal divide by 4095 before commit.
// Flow: one transaction in flight; the next is accepted only after the last is committed,
// and the commit waits while the previous result is still held for m_tready.
// Reset: aresetn synchronous, active low; registers to defaults, flags and scan cleared.
module adc_channel_scan_scaler #(
    parameter int MAX_SLOTS = acss_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [acss_pkg::S_TDATA_W-1:0]   s_tdata,   // sample[11:0], channel[16:12]
    input  logic [1:0]                       s_tuser,   // kind[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[1:0], value[17:2], start_request[18], start_channel[23:19], running[24]
    output logic [acss_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_we,
    input  logic [acss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [acss_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    acss_pkg::ctrl_cmd_t  cmd;
    acss_pkg::dp_status_t dp_status;

    acss_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    acss_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .dp_status (dp_status)
    );

endmodule
